/* hdl/itoa_pkg.sv */
// ----------------------------------------------------------------------------
// itoa_pkg
// Shared widths, character codes and digit glyph lookup for the
// integer to radix ASCII converter.
// ----------------------------------------------------------------------------
package itoa_pkg;

  localparam int unsigned NUM_W       = 32;
  localparam int unsigned RADIX_W     = 6;
  localparam int unsigned CHAR_W      = 8;
  localparam int unsigned DIGIT_W     = 6;
  localparam int unsigned DIGIT_SLOTS = 32;

  // quotient bits produced per cycle by the shared divide step
  localparam int unsigned STEP_BITS   = 4;
  localparam int unsigned STEPS       = NUM_W / STEP_BITS;

  localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
  localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(36);

  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_A     = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_NONE  = 8'h00;

  localparam logic [DIGIT_W-1:0] DIGIT_TEN = DIGIT_W'(10);
  localparam logic [DIGIT_W-1:0] DIGIT_END = DIGIT_W'(36);

  // '0'-'9' then 'a'-'z'; codes past 'z' map to zero
  function automatic logic [CHAR_W-1:0] glyph(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < DIGIT_TEN) begin
      c = CHAR_ZERO + CHAR_W'(d);
    end else if (d < DIGIT_END) begin
      c = CHAR_A + CHAR_W'(d - DIGIT_TEN);
    end else begin
      c = CHAR_NONE;
    end
    return c;
  endfunction

endpackage

/* hdl/itoa_cfg_if.sv */
// ----------------------------------------------------------------------------
// itoa_cfg_if
// Radix register write channel.
// ----------------------------------------------------------------------------
interface itoa_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [itoa_pkg::RADIX_W-1:0]  radix;

  modport source (output valid, output radix, input ready);
  modport sink   (input valid, input radix, output ready);
endinterface

/* hdl/itoa_num_if.sv */
// ----------------------------------------------------------------------------
// itoa_num_if
// Input channel: one signed integer per item.
// ----------------------------------------------------------------------------
interface itoa_num_if;
  logic                              valid;
  logic                              ready;
  logic signed [itoa_pkg::NUM_W-1:0] number;

  modport source (output valid, output number, input ready);
  modport sink   (input valid, input number, output ready);
endinterface

/* hdl/itoa_char_if.sv */
// ----------------------------------------------------------------------------
// itoa_char_if
// Output channel: one ASCII character per item.
// ----------------------------------------------------------------------------
interface itoa_char_if;
  logic                         valid;
  logic                         ready;
  logic [itoa_pkg::CHAR_W-1:0]  character;
  logic                         last;
  logic                         empty_res;

  modport source (output valid, output character, output last, output empty_res,
                  input ready);
  modport sink   (input valid, input character, input last, input empty_res,
                  output ready);
endinterface

/* hdl/itoa_ram.sv */
// ----------------------------------------------------------------------------
// itoa_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module itoa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/integer_to_radix_ascii_core.sv */
// ----------------------------------------------------------------------------
// integer_to_radix_ascii_core
// Signed 32-bit integer to ASCII text in a programmable base (2 to 36).
// ----------------------------------------------------------------------------
// One number is converted at a time; the input is not ready until the last
// character has been taken. Digits come from a shared divide-by-radix unit
// that retires 4 quotient bits per cycle, and digits land least significant
// first in a small RAM. Text then leaves most significant first: a '-' for
// negative input, then each digit passes a RAM read, a load and the output
// handshake, which waits while the output is stalled.
// A base outside 2..36 gives one item with empty_res set.
// The radix register resets to 10 and is always ready for writes.
module integer_to_radix_ascii_core #(
  parameter int unsigned DIGIT_SLOTS = itoa_pkg::DIGIT_SLOTS
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  itoa_cfg_if.sink      cfg_i,
  itoa_num_if.sink      num_i,
  itoa_char_if.source   char_o
);

  localparam int unsigned AW    = (DIGIT_SLOTS > 1) ? $clog2(DIGIT_SLOTS) : 1;
  localparam int unsigned CNT_W = $clog2(DIGIT_SLOTS + 1);
  localparam int unsigned SW    = $clog2(itoa_pkg::STEPS);
  localparam int unsigned NW    = itoa_pkg::NUM_W;
  localparam int unsigned RW    = itoa_pkg::RADIX_W;
  localparam int unsigned DW    = itoa_pkg::DIGIT_W;
  localparam int unsigned SB    = itoa_pkg::STEP_BITS;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_DIV  = 5'b00010,
    ST_RD   = 5'b00100,
    ST_LD   = 5'b01000,
    ST_OUT  = 5'b10000
  } state_e;

  state_e                        state_q, state_d;
  logic [RW-1:0]                 radix_q;
  logic [NW-1:0]                 mag_q, mag_d;
  logic [DW-1:0]                 rem_q, rem_d;
  logic [SW-1:0]                 step_q, step_d;
  logic [CNT_W-1:0]              count_q, count_d;
  logic [CNT_W-1:0]              idx_q, idx_d;
  logic                          neg_q, neg_d;
  logic [itoa_pkg::CHAR_W-1:0]   char_q, char_d;
  logic                          last_q, last_d;
  logic                          empty_q, empty_d;

  // shared divide step
  logic [DW-1:0]                 rem_n;
  logic [SB-1:0]                 quo_n;
  logic [DW:0]                   trial;

  logic                          ram_we;
  logic [DW-1:0]                 ram_rdata;
  logic                          in_acc;
  logic                          radix_ok;
  logic [NW-1:0]                 num_u;

  assign cfg_i.ready = 1'b1;
  assign num_i.ready = (state_q == ST_IDLE);
  assign in_acc      = num_i.valid && num_i.ready;
  assign radix_ok    = (radix_q >= itoa_pkg::RADIX_MIN) && (radix_q <= itoa_pkg::RADIX_MAX);
  assign num_u       = NW'(num_i.number);

  assign char_o.valid     = (state_q == ST_OUT);
  assign char_o.character = char_q;
  assign char_o.last      = last_q;
  assign char_o.empty_res = empty_q;

  // restoring division, SB bits of the magnitude per cycle
  always_comb begin
    rem_n = rem_q;
    quo_n = '0;
    trial = '0;
    for (int k = 0; k < SB; k++) begin
      trial = {rem_n, mag_q[NW-1-k]};
      if (trial >= (DW+1)'(radix_q)) begin
        rem_n          = DW'(trial - (DW+1)'(radix_q));
        quo_n[SB-1-k]  = 1'b1;
      end else begin
        rem_n = trial[DW-1:0];
      end
    end
  end

  always_comb begin
    state_d = state_q;
    mag_d   = mag_q;
    rem_d   = rem_q;
    step_d  = step_q;
    count_d = count_q;
    idx_d   = idx_q;
    neg_d   = neg_q;
    char_d  = char_q;
    last_d  = last_q;
    empty_d = empty_q;
    ram_we  = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (!radix_ok) begin
            char_d  = itoa_pkg::CHAR_NONE;
            last_d  = 1'b1;
            empty_d = 1'b1;
            state_d = ST_OUT;
          end else begin
            neg_d   = num_u[NW-1];
            mag_d   = num_u[NW-1] ? (NW'(0) - num_u) : num_u;
            rem_d   = '0;
            step_d  = '0;
            count_d = '0;
            state_d = ST_DIV;
          end
        end
      end

      ST_DIV: begin
        mag_d  = {mag_q[NW-SB-1:0], quo_n};
        rem_d  = rem_n;
        step_d = step_q + SW'(1);
        if (step_q == SW'(itoa_pkg::STEPS - 1)) begin
          rem_d = '0;
          // digits beyond the store are dropped
          if (count_q < CNT_W'(DIGIT_SLOTS)) begin
            ram_we  = 1'b1;
            count_d = count_q + CNT_W'(1);
          end
          if (mag_d == '0) begin
            idx_d = count_d;
            if (neg_q) begin
              char_d  = itoa_pkg::CHAR_MINUS;
              last_d  = 1'b0;
              empty_d = 1'b0;
              state_d = ST_OUT;
            end else begin
              state_d = ST_RD;
            end
          end
        end
      end

      ST_RD: begin
        state_d = ST_LD;
      end

      ST_LD: begin
        char_d  = itoa_pkg::glyph(ram_rdata);
        last_d  = (idx_q == CNT_W'(1));
        empty_d = 1'b0;
        idx_d   = idx_q - CNT_W'(1);
        state_d = ST_OUT;
      end

      ST_OUT: begin
        if (char_o.ready) begin
          state_d = last_q ? ST_IDLE : ST_RD;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  itoa_ram #(
    .WIDTH (DW),
    .DEPTH (DIGIT_SLOTS)
  ) u_digit_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (AW'(count_q)),
    .wdata_i (rem_n),
    .raddr_i (AW'(idx_q - CNT_W'(1))),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      radix_q <= itoa_pkg::RADIX_RESET;
      step_q  <= '0;
      count_q <= '0;
      idx_q   <= '0;
      neg_q   <= 1'b0;
      mag_q   <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      count_q <= count_d;
      idx_q   <= idx_d;
      neg_q   <= neg_d;
      mag_q   <= mag_d;
      if (cfg_i.valid && cfg_i.ready) begin
        radix_q <= cfg_i.radix;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q   <= rem_d;
    char_q  <= char_d;
    last_q  <= last_d;
    empty_q <= empty_d;
  end

endmodule
